### hdl/mskf_pkg.sv
// ----------------------------------------------------------------------------
// mskf_pkg: shared types and constants of the multichannel scalar Kalman filter
// Holds the register map, reset values, sequencer states and the structs that
// connect the sequencer to the channel store and the multiply-accumulate unit.
// ----------------------------------------------------------------------------
package mskf_pkg;

    localparam int CHANNELS_DEF = 16;
    localparam int CH_IDX_W     = 6;
    localparam int DIV_STEPS    = 32;
    localparam int CFG_IDX_W    = 3;

    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_COVARIANCE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_ESTIMATE   = 3'd3;

    localparam logic [31:0] PROCESS_NOISE_RST      = 32'd1073742;
    localparam logic [31:0] MEASUREMENT_NOISE_RST  = 32'd53687091;
    localparam logic [31:0] INITIAL_COVARIANCE_RST = 32'd1073741824;
    localparam logic [15:0] INITIAL_ESTIMATE_RST   = 16'd0;

    localparam logic [15:0] SYNC_WORD    = 16'h7FFF;
    localparam logic [15:0] SYNC_REPLACE = 16'h7FFE;
    localparam logic [32:0] GAIN_ONE     = 33'h1_0000_0000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_PRED,
        S_DEN,
        S_DIV,
        S_M0,
        S_M1,
        S_M2,
        S_XUPD,
        S_P1,
        S_P2,
        S_WB
    } t_state;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_SHADD
    } t_acc_op;

    typedef struct packed {
        logic [31:0] q;
        logic [31:0] r;
        logic [31:0] init_cov;
        logic [15:0] init_est;
    } t_cfg;

    typedef struct packed {
        logic                rd;
        logic                wr;
        logic [CH_IDX_W-1:0] idx;
        logic [31:0]         est;
        logic [31:0]         cov;
    } t_store_req;

    typedef struct packed {
        logic        started;
        logic [31:0] est;
        logic [31:0] cov;
    } t_store_rsp;

    typedef struct packed {
        t_acc_op     op;
        logic [32:0] a;
        logic [15:0] b;
    } t_mac_req;

endpackage

### hdl/mskf_store.sv
// ----------------------------------------------------------------------------
// mskf_store: per-channel filter state
// Estimate and covariance memories with registered reads, plus one started
// flag per channel that reset clears.
// ----------------------------------------------------------------------------
module mskf_store
    import mskf_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_store_req i_req,
    output t_store_rsp o_rsp
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [31:0]         r_est_mem [CHANNELS];
    logic [31:0]         r_cov_mem [CHANNELS];
    logic [CHANNELS-1:0] r_started;
    logic [31:0]         r_rd_est;
    logic [31:0]         r_rd_cov;
    logic                r_rd_started;
    logic [CH_W-1:0]     idx;

    assign idx = i_req.idx[CH_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_req.wr) begin
            r_est_mem[idx] <= i_req.est;
            r_cov_mem[idx] <= i_req.cov;
        end
        if (i_req.rd) begin
            r_rd_est <= r_est_mem[idx];
            r_rd_cov <= r_cov_mem[idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started    <= '0;
            r_rd_started <= 1'b0;
        end else begin
            if (i_req.wr) begin
                r_started[idx] <= 1'b1;
            end
            if (i_req.rd) begin
                r_rd_started <= r_started[idx];
            end
        end
    end

    assign o_rsp.started = r_rd_started;
    assign o_rsp.est     = r_rd_est;
    assign o_rsp.cov     = r_rd_cov;

endmodule

### hdl/mskf_mac.sv
// ----------------------------------------------------------------------------
// mskf_mac: shared multiply-accumulate unit
// A registered 33 x 16 multiplier feeding an accumulator that holds, loads the
// product or adds it to the accumulator shifted down by 16 bits.
// ----------------------------------------------------------------------------
module mskf_mac
    import mskf_pkg::*;
(
    input  logic        i_clk,
    input  t_mac_req    i_req,
    output logic [49:0] o_acc
);

    logic [48:0] r_prod;
    logic [49:0] r_acc;
    logic [49:0] n_acc;

    always_comb begin
        case (i_req.op)
            ACC_LOAD:  n_acc = {1'b0, r_prod};
            ACC_SHADD: n_acc = {16'd0, r_acc[49:16]} + {1'b0, r_prod};
            default:   n_acc = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= {16'd0, i_req.a} * {33'd0, i_req.b};
        r_acc  <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

### hdl/mskf_core.sv
// ----------------------------------------------------------------------------
// mskf_core: filter step sequencer
// Runs one filter step per in-range request: prediction, a bit-serial
// restoring division for the gain when needed, and the estimate and covariance
// updates on the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
module mskf_core
    import mskf_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [3:0]         i_channel,
    input  logic signed [15:0] i_measurement,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output logic [3:0]         o_res_channel,
    output logic signed [15:0] o_res_filtered,
    output t_store_req         o_store_req,
    input  t_store_rsp         i_store_rsp,
    output t_mac_req           o_mac_req,
    input  logic [49:0]        i_mac_acc
);

    t_state             r_state;
    t_state             n_state;
    logic [3:0]         r_chan;
    logic [3:0]         n_chan;
    logic signed [15:0] r_meas;
    logic signed [15:0] n_meas;
    logic               r_skip;
    logic               n_skip;
    logic [31:0]        r_p;
    logic [31:0]        n_p;
    logic [31:0]        r_x;
    logic [31:0]        n_x;
    logic [32:0]        r_diff;
    logic [32:0]        n_diff;
    logic [32:0]        r_den;
    logic [32:0]        n_den;
    logic [32:0]        r_rem;
    logic [32:0]        n_rem;
    logic [31:0]        r_k;
    logic [31:0]        n_k;
    logic               r_neg;
    logic               n_neg;
    logic [32:0]        r_mag;
    logic [32:0]        n_mag;
    logic [4:0]         r_cnt;
    logic [4:0]         n_cnt;

    logic [31:0] cov_cur;
    logic [31:0] x_cur;
    logic [32:0] p_sum;
    logic [32:0] den_sum;
    logic [33:0] div_sh;
    logic        div_ge;
    logic [33:0] div_sub;
    logic [31:0] delta;
    logic [32:0] one_minus_k;
    logic [32:0] x_abs;
    logic [16:0] x_whole;
    logic [15:0] whole;
    logic        in_range;

    assign cov_cur     = i_store_rsp.started ? i_store_rsp.cov : i_cfg.init_cov;
    assign x_cur       = i_store_rsp.started ? i_store_rsp.est : {i_cfg.init_est, 16'd0};
    assign p_sum       = {1'b0, cov_cur} + {1'b0, i_cfg.q};
    assign den_sum     = {1'b0, r_p} + {1'b0, i_cfg.r};
    assign div_sh      = {r_rem, 1'b0};
    assign div_ge      = div_sh >= {1'b0, r_den};
    assign div_sub     = div_sh - {1'b0, r_den};
    assign delta       = i_mac_acc[47:16];
    assign one_minus_k = GAIN_ONE - {1'b0, r_k};
    assign x_abs       = r_x[31] ? (33'd0 - {r_x[31], r_x}) : {1'b0, r_x};
    assign x_whole     = x_abs[32:16];
    assign whole       = r_x[31] ? 16'(17'd0 - x_whole) : x_whole[15:0];
    assign in_range    = 32'(i_channel) < CHANNELS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chan <= n_chan;
        r_meas <= n_meas;
        r_skip <= n_skip;
        r_p    <= n_p;
        r_x    <= n_x;
        r_diff <= n_diff;
        r_den  <= n_den;
        r_rem  <= n_rem;
        r_k    <= n_k;
        r_neg  <= n_neg;
        r_mag  <= n_mag;
        r_cnt  <= n_cnt;
    end

    always_comb begin
        n_state        = r_state;
        n_chan         = r_chan;
        n_meas         = r_meas;
        n_skip         = r_skip;
        n_p            = r_p;
        n_x            = r_x;
        n_diff         = r_diff;
        n_den          = r_den;
        n_rem          = r_rem;
        n_k            = r_k;
        n_neg          = r_neg;
        n_mag          = r_mag;
        n_cnt          = r_cnt;
        o_in_ready     = 1'b0;
        o_res_valid    = 1'b0;
        o_store_req    = '{rd: 1'b0, wr: 1'b0, idx: CH_IDX_W'(r_chan), est: r_x,
                           cov: i_mac_acc[47:16]};
        o_mac_req      = '{op: ACC_HOLD, a: '0, b: '0};

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_chan  = i_channel;
                    n_meas  = i_measurement;
                    n_skip  = !in_range;
                    n_state = in_range ? S_READ : S_WB;
                end
            end
            S_READ: begin
                o_store_req.rd = 1'b1;
                n_state        = S_PRED;
            end
            S_PRED: begin
                n_p     = p_sum[32] ? 32'hFFFF_FFFF : p_sum[31:0];
                n_x     = x_cur;
                n_diff  = {r_meas[15], r_meas, 16'd0} - {x_cur[31], x_cur};
                n_state = S_DEN;
            end
            S_DEN: begin
                n_den = den_sum;
                n_rem = {1'b0, r_p};
                n_cnt = '0;
                n_neg = r_diff[32];
                n_mag = r_diff[32] ? (33'd0 - r_diff) : r_diff;
                if (den_sum == '0) begin
                    n_k     = '0;
                    n_state = S_M0;
                end else if (i_cfg.r == '0) begin
                    n_k     = 32'hFFFF_FFFF;
                    n_state = S_M0;
                end else begin
                    n_k     = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem = div_ge ? div_sub[32:0] : div_sh[32:0];
                n_k   = {r_k[30:0], div_ge};
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(DIV_STEPS - 1)) begin
                    n_state = S_M0;
                end
            end
            S_M0: begin
                o_mac_req = '{op: ACC_HOLD, a: r_mag, b: r_k[15:0]};
                n_state   = S_M1;
            end
            S_M1: begin
                o_mac_req = '{op: ACC_LOAD, a: r_mag, b: r_k[31:16]};
                n_state   = S_M2;
            end
            S_M2: begin
                o_mac_req = '{op: ACC_SHADD, a: '0, b: '0};
                n_state   = S_XUPD;
            end
            S_XUPD: begin
                o_mac_req = '{op: ACC_HOLD, a: one_minus_k, b: r_p[15:0]};
                n_x       = r_neg ? (r_x - delta) : (r_x + delta);
                n_state   = S_P1;
            end
            S_P1: begin
                o_mac_req = '{op: ACC_LOAD, a: one_minus_k, b: r_p[31:16]};
                n_state   = S_P2;
            end
            S_P2: begin
                o_mac_req = '{op: ACC_SHADD, a: '0, b: '0};
                n_state   = S_WB;
            end
            S_WB: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    o_store_req.wr = !r_skip;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res_channel  = r_chan;
    assign o_res_filtered = r_skip ? 16'sd0 :
                            (whole == SYNC_WORD) ? SYNC_REPLACE : whole;

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("core accepted a request while a step was under way");

    a_write_on_handover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_store_req.wr |-> (o_res_valid && i_res_ready && !r_skip))
        else $error("channel state written without a delivered result");

    a_zero_den_zero_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_M0 && r_den == '0) |-> (r_k == '0))
        else $error("nonzero gain with zero denominator");

    a_no_sync_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_res_filtered != SYNC_WORD))
        else $error("result equals the packet sync word");
`endif

endmodule

### hdl/multichannel_scalar_kalman.sv
// ----------------------------------------------------------------------------
// multichannel_scalar_kalman: one-dimensional Kalman filter over many channels
// Each channel keeps its own estimate and covariance and shares the noise
// settings; every sample yields one filtered estimate for its channel.
// ----------------------------------------------------------------------------
//  Channel   Handshake                   Payload
//  input     i_in_valid / o_in_ready     i_channel, i_measurement
//  output    o_out_valid / i_out_ready   o_channel_out, o_filtered
//  config    i_cfg_we (no wait)          i_cfg_index, i_cfg_data
//
//  A sample passes through prediction, the 32-step bit-serial gain divider and
//  the updates on its way to the result register; the divider is skipped when no
//  division is needed, and a channel number out of range skips the whole step.
//  A new sample is accepted only between steps, also while a result waits.
//  A step holds before writing its result while a full output register is not read.
//  Reset restores the register defaults and marks every channel not started.
// ----------------------------------------------------------------------------
module multichannel_scalar_kalman
    import mskf_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [3:0]           i_channel,
    input  logic signed [15:0]   i_measurement,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [3:0]           o_channel_out,
    output logic signed [15:0]   o_filtered
);

    t_cfg               r_cfg;
    logic               r_out_valid;
    logic [3:0]         r_out_chan;
    logic signed [15:0] r_out_filt;
    logic               res_valid;
    logic               res_ready;
    logic [3:0]         res_channel;
    logic signed [15:0] res_filtered;
    t_store_req         store_req;
    t_store_rsp         store_rsp;
    t_mac_req           mac_req;
    logic [49:0]        mac_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.q        <= PROCESS_NOISE_RST;
            r_cfg.r        <= MEASUREMENT_NOISE_RST;
            r_cfg.init_cov <= INITIAL_COVARIANCE_RST;
            r_cfg.init_est <= INITIAL_ESTIMATE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PROCESS_NOISE:      r_cfg.q        <= i_cfg_data;
                REG_MEASUREMENT_NOISE:  r_cfg.r        <= i_cfg_data;
                REG_INITIAL_COVARIANCE: r_cfg.init_cov <= i_cfg_data;
                REG_INITIAL_ESTIMATE:   r_cfg.init_est <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out_chan <= res_channel;
            r_out_filt <= res_filtered;
        end
    end

    mskf_core #(
        .CHANNELS(CHANNELS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_channel      (i_channel),
        .i_measurement  (i_measurement),
        .o_res_valid    (res_valid),
        .i_res_ready    (res_ready),
        .o_res_channel  (res_channel),
        .o_res_filtered (res_filtered),
        .o_store_req    (store_req),
        .i_store_rsp    (store_rsp),
        .o_mac_req      (mac_req),
        .i_mac_acc      (mac_acc)
    );

    mskf_store #(
        .CHANNELS(CHANNELS)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (store_req),
        .o_rsp   (store_rsp)
    );

    mskf_mac u_mac (
        .i_clk (i_clk),
        .i_req (mac_req),
        .o_acc (mac_acc)
    );

    assign o_out_valid   = r_out_valid;
    assign o_channel_out = r_out_chan;
    assign o_filtered    = r_out_filt;

endmodule

### tb/sv/tb_multichannel_scalar_kalman.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multichannel_scalar_kalman: self-checking bench for the multichannel filter
// A scoreboard class keeps its own copy of every channel's estimate and
// covariance and predicts each filtered estimate. Directed requests cover the
// sample and noise extremes, a zero denominator, a gain of one and the sync
// word. Random phases with changing noise settings and random idling follow.
// ----------------------------------------------------------------------------
module tb_multichannel_scalar_kalman
    import mskf_pkg::*;
();

    localparam int NUM_CH          = CHANNELS_DEF;
    localparam int RESULT_LATENCY  = 42;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 92;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_INDEX = '1;

    typedef struct packed {
        logic [3:0]         channel;
        logic signed [15:0] filtered;
    } t_estimate;

    class estimate_checker;
        bit [31:0] q_noise;
        bit [31:0] r_noise;
        bit [31:0] cov_start;
        bit [15:0] est_start;
        bit [31:0] chan_est[NUM_CH];
        bit [31:0] chan_cov[NUM_CH];
        bit        chan_live[NUM_CH];
        t_estimate expected_estimates[$];
        int        mismatches;
        int        checked;

        function new();
            q_noise    = PROCESS_NOISE_RST;
            r_noise    = MEASUREMENT_NOISE_RST;
            cov_start  = INITIAL_COVARIANCE_RST;
            est_start  = INITIAL_ESTIMATE_RST;
            mismatches = 0;
            checked    = 0;
            foreach (chan_live[i]) begin
                chan_live[i] = 1'b0;
                chan_est[i]  = '0;
                chan_cov[i]  = '0;
            end
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                REG_PROCESS_NOISE:      q_noise   = data;
                REG_MEASUREMENT_NOISE:  r_noise   = data;
                REG_INITIAL_COVARIANCE: cov_start = data;
                REG_INITIAL_ESTIMATE:   est_start = data[15:0];
                default: ;
            endcase
        endfunction

        function void note_sample(logic [3:0] ch, logic signed [15:0] meas);
            bit [32:0] var_sum;
            bit [31:0] var_pred;
            bit [32:0] denom;
            bit [63:0] quot;
            bit [31:0] gain;
            longint    x_now;
            longint    innov;
            bit [63:0] innov_mag;
            bit [95:0] prod;
            longint    step;
            bit [95:0] cov_prod;
            longint    whole;
            t_estimate item;
            item.channel  = ch;
            item.filtered = '0;
            if (int'(ch) < NUM_CH) begin
                if (!chan_live[ch]) begin
                    chan_live[ch] = 1'b1;
                    chan_cov[ch]  = cov_start;
                    chan_est[ch]  = {est_start, 16'h0000};
                end
                var_sum  = {1'b0, chan_cov[ch]} + {1'b0, q_noise};
                var_pred = var_sum[32] ? 32'hFFFF_FFFF : var_sum[31:0];
                denom    = {1'b0, var_pred} + {1'b0, r_noise};
                if (denom == '0) begin
                    gain = '0;
                end else begin
                    quot = {var_pred, 32'h0000_0000} / {31'h0, denom};
                    gain = (quot[63:32] != '0) ? 32'hFFFF_FFFF : quot[31:0];
                end
                x_now     = longint'(signed'(chan_est[ch]));
                innov     = longint'(meas) * 65536 - x_now;
                innov_mag = (innov < 0) ? 64'(-innov) : 64'(innov);
                prod      = 96'(innov_mag) * 96'(gain);
                step      = longint'(prod[95:32]);
                x_now     = (innov < 0) ? x_now - step : x_now + step;
                chan_est[ch] = x_now[31:0];
                cov_prod  = (96'h1_0000_0000 - 96'(gain)) * 96'(var_pred);
                chan_cov[ch] = cov_prod[63:32];
                whole = (x_now < 0) ? -((-x_now) >>> 16) : (x_now >>> 16);
                if (whole == longint'(SYNC_WORD)) begin
                    whole = longint'(SYNC_REPLACE);
                end
                item.filtered = whole[15:0];
            end
            expected_estimates.push_back(item);
        endfunction

        function void check_result(logic [3:0] ch, logic signed [15:0] filt);
            t_estimate want;
            if (expected_estimates.size() == 0) begin
                $error("unexpected result: channel_out %0d filtered %0d", ch, filt);
                mismatches++;
                return;
            end
            want = expected_estimates.pop_front();
            checked++;
            if (ch !== want.channel) begin
                $error("channel_out mismatch: expected %0d, actual %0d", want.channel, ch);
                mismatches++;
            end
            if (filt !== want.filtered) begin
                $error("filtered mismatch: expected %0d, actual %0d",
                       $signed(want.filtered), filt);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_estimates.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0]          i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [3:0]           i_channel;
    logic signed [15:0]   i_measurement;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [3:0]           o_channel_out;
    logic signed [15:0]   o_filtered;

    estimate_checker    board;
    bit                 no_idle;
    int                 cycle_count = 0;
    int                 samples_sent = 0;
    int                 settings_used = 0;
    logic signed [15:0] last_meas[NUM_CH];

    multichannel_scalar_kalman #(
        .CHANNELS(NUM_CH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_channel     (i_channel),
        .i_measurement (i_measurement),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_channel_out (o_channel_out),
        .o_filtered    (o_filtered)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** multichannel_scalar_kalman: FAILED **");
            $finish;
        end
    end

    task automatic send_sample(input logic [3:0] ch, input logic signed [15:0] meas);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_channel     <= ch;
        i_measurement <= meas;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_sample(ch, meas);
        last_meas[ch] = meas;
        samples_sent++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        board.write_register(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [31:0] q, input logic [31:0] r,
                                  input logic [31:0] cov, input logic [31:0] est);
        write_reg(REG_PROCESS_NOISE, q);
        write_reg(REG_MEASUREMENT_NOISE, r);
        write_reg(REG_INITIAL_COVARIANCE, cov);
        write_reg(REG_INITIAL_ESTIMATE, est);
        settings_used++;
    endtask

    function automatic logic [31:0] pick_q230(logic [31:0] dflt);
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return dflt;
            default: return $urandom >> $urandom_range(0, 31);
        endcase
    endfunction

    function automatic logic signed [15:0] pick_measurement(logic [3:0] ch);
        int base;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                base = int'(last_meas[ch]) + int'($urandom_range(0, 511)) - 256;
                if (base > 32767) base = 32767;
                if (base < -32768) base = -32768;
                return base[15:0];
            end
            9: begin
                case ($urandom_range(0, 3))
                    0:       return 16'sh7FFF;
                    1:       return 16'sh8000;
                    2:       return 16'sh0000;
                    default: return 16'shFFFF;
                endcase
            end
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        int stall;
        i_out_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            board.check_result(o_channel_out, o_filtered);
        end
    end

    initial begin
        logic [3:0]         ch;
        logic signed [15:0] meas;
        board = new();
        foreach (last_meas[i]) last_meas[i] = '0;
        no_idle = 1'b0;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= REG_PROCESS_NOISE;
        i_cfg_data    <= '0;
        i_in_valid    <= 1'b0;
        i_channel     <= '0;
        i_measurement <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: sample extremes and truncation of small negatives.
        settings_used++;
        send_sample(4'd0, 16'sh0000);
        send_sample(4'd0, 16'sh7FFF);
        send_sample(4'd0, 16'sh8000);
        send_sample(4'd1, 16'sh8000);
        send_sample(4'd1, 16'sh7FFF);
        send_sample(4'd2, 16'sh0001);
        send_sample(4'd2, 16'shFFFF);
        send_sample(4'd3, 16'sh3039);
        drain_results();

        // Zero noise and zero covariance leave the estimate at the sync word.
        apply_settings('0, '0, '0, 32'h0000_7FFF);
        send_sample(4'd4, 16'sh7FFF);
        send_sample(4'd4, 16'sh8000);
        send_sample(4'd5, 16'sh8000);
        drain_results();

        // Full covariance with no measurement noise saturates the gain.
        apply_settings('0, '0, '1, 32'hA5A5_8000);
        send_sample(4'd6, 16'sh7FFF);
        send_sample(4'd6, 16'sh0000);
        send_sample(4'd7, 16'sh8000);
        drain_results();

        // Saturated prediction; a write to an unused index must change nothing.
        apply_settings('1, '1, '1, 32'h5A5A_1234);
        write_reg(REG_LAST_INDEX, $urandom);
        send_sample(4'd8, 16'sh7FFF);
        send_sample(4'd8, 16'sh8000);
        send_sample(4'd9, 16'sh0000);
        drain_results();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            no_idle = (ph % 3 == 1);
            apply_settings(pick_q230(PROCESS_NOISE_RST), pick_q230(MEASUREMENT_NOISE_RST),
                           pick_q230(INITIAL_COVARIANCE_RST), $urandom);
            if ($urandom_range(0, 1) == 0) begin
                write_reg(CFG_IDX_W'($urandom_range(REG_INITIAL_ESTIMATE + 1,
                                                    REG_LAST_INDEX)), $urandom);
            end
            repeat (ITEMS_PER_PHASE) begin
                ch   = 4'($urandom_range(0, NUM_CH - 1));
                meas = pick_measurement(ch);
                send_sample(ch, meas);
            end
            drain_results();
        end

        repeat (RESULT_LATENCY + 8) @(posedge i_clk);
        $display("Sent %0d samples over %0d noise settings; %0d estimates compared.",
                 samples_sent, settings_used, board.checked);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("** multichannel_scalar_kalman: PASSED **");
        end else begin
            if (board.pending() != 0) begin
                $error("%0d expected estimates never arrived", board.pending());
            end
            $display("** multichannel_scalar_kalman: FAILED **");
        end
        $finish;
    end

endmodule
